### design/mdw_pkg.sv
// Shared types and constants for the multiword divide-by-word block.
`default_nettype none
package mdw_pkg;

    localparam int DATA_BITS = 64;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_zero;
        logic last_step;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### design/mdw_dp.sv
// Datapath: divisor register, running remainder, radix-2 restoring divider, output register.
`default_nettype none
module mdw_dp
    import mdw_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_divisor_we,
    input  wire logic [DATA_BITS-1:0] i_divisor,
    input  wire logic [DATA_BITS-1:0] i_dividend_word,
    input  wire logic                 i_last_word,
    input  wire logic                 i_ready,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    output logic                      o_valid,
    output logic [DATA_BITS-1:0]      o_quotient_word,
    output logic [DATA_BITS-1:0]      o_remainder,
    output logic                      o_last,
    output logic                      o_divide_by_zero
);

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(2 * W + 1);

    logic [W-1:0]   r_divisor, n_divisor;
    logic [W-1:0]   r_run, n_run;
    logic [W-1:0]   r_rem, n_rem;
    logic [W-1:0]   r_quo, n_quo;
    logic [2*W-1:0] r_sh, n_sh;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_last, n_last;
    logic           r_dz, n_dz;
    logic           r_ovalid, n_ovalid;
    logic [W-1:0]   r_oquo, n_oquo;
    logic [W-1:0]   r_orem, n_orem;
    logic           r_olast, n_olast;
    logic           r_odz, n_odz;

    logic [W-1:0]   word;
    logic [W-1:0]   shifted;
    logic [W:0]     diff;
    logic           take;
    logic           dz_now;
    logic           hi_below;

    assign word     = i_dividend_word[W-1:0];
    assign dz_now   = (r_divisor == '0);
    assign hi_below = (r_run < r_divisor);
    assign shifted  = {r_rem[W-2:0], r_sh[2*W-1]};
    assign diff     = {1'b0, shifted} - {1'b0, r_divisor};
    assign take     = r_rem[W-1] | ~diff[W];

    always_comb begin
        n_divisor = i_divisor_we ? i_divisor[W-1:0] : r_divisor;
        n_run     = r_run;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_sh      = r_sh;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_dz      = r_dz;
        n_ovalid  = r_ovalid & ~i_ready;
        n_oquo    = r_oquo;
        n_orem    = r_orem;
        n_olast   = r_olast;
        n_odz     = r_odz;
        if (i_cmd.load) begin
            n_last = i_last_word;
            n_dz   = dz_now;
            n_quo  = '0;
            if (hi_below && !dz_now) begin
                // remainder already reduced: only the low word needs stepping
                n_rem = r_run;
                n_sh  = {word, {W{1'b0}}};
                n_cnt = CW'(W);
            end else begin
                n_rem = '0;
                n_sh  = {r_run, word};
                n_cnt = CW'(2 * W);
            end
        end
        if (i_cmd.step) begin
            n_rem = take ? diff[W-1:0] : shifted;
            n_quo = {r_quo[W-2:0], take};
            n_sh  = {r_sh[2*W-2:0], 1'b0};
            n_cnt = r_cnt - CW'(1);
        end
        if (i_cmd.emit) begin
            n_ovalid = 1'b1;
            n_oquo   = r_dz ? r_sh[W-1:0] : r_quo;
            n_orem   = r_dz ? '0 : r_rem;
            n_olast  = r_last;
            n_odz    = r_dz;
            n_run    = (r_dz || r_last) ? '0 : r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divisor <= W'(1);
            r_run     <= '0;
            r_ovalid  <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_divisor <= n_divisor;
            r_run     <= n_run;
            r_ovalid  <= n_ovalid;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_sh    <= n_sh;
        r_last  <= n_last;
        r_dz    <= n_dz;
        r_oquo  <= n_oquo;
        r_orem  <= n_orem;
        r_olast <= n_olast;
        r_odz   <= n_odz;
    end

    assign o_status.div_zero  = dz_now;
    assign o_status.last_step = (r_cnt == CW'(1));
    assign o_status.out_free  = ~r_ovalid | i_ready;

    assign o_valid          = r_ovalid;
    assign o_quotient_word  = DATA_BITS'(r_oquo);
    assign o_remainder      = DATA_BITS'(r_orem);
    assign o_last           = r_olast;
    assign o_divide_by_zero = r_odz;

endmodule
`default_nettype wire

### design/mdw_ctrl.sv
// Controller: sequences load, divide steps and hand-off to the output register.
`default_nettype none
module mdw_ctrl
    import mdw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_status.div_zero ? S_DONE : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.last_step) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

### design/multiword_divide_by_word_top.sv
// Top level: multi-word number divided by a one-word divisor, one word per handshake.
// Each word is accepted, then divided one quotient bit per cycle: WORD_BITS divide steps,
// or 2*WORD_BITS when the running remainder is not below the divisor, none for a zero
// divisor; the result then goes into the output register before a new word is accepted.
// The next word is taken while a finished word waits in the output register.
// Synchronous active-low reset: divisor = 1, running remainder = 0, no output pending.
`default_nettype none
module multiword_divide_by_word_top
    import mdw_pkg::*;
#(
    parameter int WORD_BITS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_divisor_we,
    input  wire logic [DATA_BITS-1:0] i_divisor,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [DATA_BITS-1:0] i_dividend_word,
    input  wire logic                 i_last_word,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [DATA_BITS-1:0]      o_quotient_word,
    output logic [DATA_BITS-1:0]      o_remainder,
    output logic                      o_last,
    output logic                      o_divide_by_zero
);

    t_cmd    cmd;
    t_status status;

    mdw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mdw_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_divisor_we     (i_divisor_we),
        .i_divisor        (i_divisor),
        .i_dividend_word  (i_dividend_word),
        .i_last_word      (i_last_word),
        .i_ready          (i_ready),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_quotient_word  (o_quotient_word),
        .o_remainder      (o_remainder),
        .o_last           (o_last),
        .o_divide_by_zero (o_divide_by_zero)
    );

endmodule
`default_nettype wire
